FILE: rtl/icrt_pkg.sv
// ----------------------------------------------------------------------------
// icrt_pkg
// Shared types and constants for the custom radix text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package icrt_pkg;

  // Sizes
  localparam int NUMBER_BITS = 32;
  localparam int MAX_BASE    = 128;
  localparam int SYM_W       = 8;
  localparam int IDX_W       = $clog2(MAX_BASE);
  localparam int BASE_W      = 8;
  localparam int DIGIT_BITS  = 4;                        // quotient bits per divider cycle
  localparam int DIV_CYCLES  = NUMBER_BITS / DIGIT_BITS;
  localparam int CNT_W       = $clog2(DIV_CYCLES);
  localparam int DCNT_W      = $clog2(NUMBER_BITS + 1);
  localparam int DBUF_AW     = $clog2(NUMBER_BITS);

  // Character codes and limits
  localparam logic [SYM_W-1:0]  CH_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0]  CH_MINUS  = 8'h2D;
  localparam logic [SYM_W-1:0]  CH_LOW    = 8'd32;
  localparam logic [SYM_W-1:0]  CH_HIGH   = 8'd126;
  localparam logic [BASE_W-1:0] MIN_BASE  = 8'd2;
  localparam logic [BASE_W-1:0] TOP_BASE  = BASE_W'(MAX_BASE);

  // Item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_CONVERT = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic [IDX_W-1:0]              symbol_index;
    logic [SYM_W-1:0]              symbol;
    logic signed [NUMBER_BITS-1:0] number;
  } icrt_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] character;
    logic             last;
  } icrt_text_t;

  typedef struct packed {
    logic                   done;
    logic [NUMBER_BITS-1:0] quotient;
    logic [IDX_W-1:0]       remainder;
  } icrt_div_res_t;

endpackage

`default_nettype wire

FILE: rtl/icrt_div.sv
// ----------------------------------------------------------------------------
// icrt_div
// Iterative unsigned divider, DIGIT_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module icrt_div
  import icrt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [NUMBER_BITS-1:0] dividend,
  input  wire logic [BASE_W-1:0]      divisor,
  output icrt_div_res_t               res
);

  logic                   busy;
  logic                   done;
  logic [CNT_W-1:0]       cnt;
  logic [NUMBER_BITS-1:0] quo;
  logic [BASE_W-1:0]      rem;
  logic [BASE_W-1:0]      dvs;

  logic [NUMBER_BITS-1:0] quo_step;
  logic [BASE_W-1:0]      rem_step;
  logic [BASE_W:0]        trial;

  // restoring steps, partial remainder stays below the divisor
  always_comb begin
    quo_step = quo;
    rem_step = rem;
    trial    = '0;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      trial    = {rem_step, quo_step[NUMBER_BITS-1]};
      quo_step = {quo_step[NUMBER_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_step    = BASE_W'(trial - {1'b0, dvs});
        quo_step[0] = 1'b1;
      end else begin
        rem_step = trial[BASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quo <= quo_step;
      rem <= rem_step;
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIV_CYCLES - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem[IDX_W-1:0];

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while still iterating");
  a_rem_range: assert property (@(posedge clk) disable iff (rst) done |-> rem < dvs)
    else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

FILE: rtl/integer_to_custom_radix_text_top.sv
// ----------------------------------------------------------------------------
// integer_to_custom_radix_text_top
// Signed integer to text in a radix set by a loadable alphabet of symbols.
// ----------------------------------------------------------------------------
//
//   channel    | dir | handshake              | beat payload
//   -----------+-----+------------------------+------------------------------
//   item       | in  | item_valid/item_ready  | kind, symbol_index, symbol,
//              |     |                        | number
//   text       | out | text_valid/text_ready  | character, last
//   cfg        | in  | cfg_wen (no wait)      | cfg_wdata = base_length
//
// Load beat: writes one entry of the symbol table.
// Convert beat: the alphabet check walks the table; then each digit costs
// one iterative division, and each character two memory reads plus an
// output step that text stalls can hold.
// item_ready is high only between conversions; a finished character waits in
// the output register, so the last one may still be pending when the next
// beat is taken. Reset clears the table's valid bits at once, no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_custom_radix_text_top
  import icrt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_wen,
  input  wire logic [BASE_W-1:0] cfg_wdata,
  // input items
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire icrt_item_t        item,
  // output characters
  output logic                   text_valid,
  input  wire logic              text_ready,
  output icrt_text_t             text
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SIGN,
    S_RD_DIG,
    S_RD_SYM,
    S_PUT
  } state_t;

  state_t state;

  logic [BASE_W-1:0]      base_length;
  logic [NUMBER_BITS-1:0] magnitude;
  logic                   negative;

  // Symbol table: memory with one write and one registered read port.
  // Valid bits stand in for the all-zero reset contents.
  logic [SYM_W-1:0]    tbl_mem [MAX_BASE];
  logic [MAX_BASE-1:0] tbl_valid;
  logic [SYM_W-1:0]    tbl_q;
  logic                tbl_vld_q;
  logic                tbl_re;
  logic [IDX_W-1:0]    tbl_raddr;
  logic                tbl_we;

  // Digit buffer: digit indices, least significant first.
  logic [IDX_W-1:0]  dbuf_mem [NUMBER_BITS];
  logic [IDX_W-1:0]  dbuf_q;
  logic              dbuf_re;
  logic              dbuf_we;
  logic [DCNT_W-1:0] ndig;
  logic [DCNT_W-1:0] ndig_dec;

  // Alphabet check
  logic [BASE_W-1:0]   chk_addr;
  logic                chk_pend;
  logic                chk_more;
  logic [MAX_BASE-1:0] seen;
  logic [SYM_W-1:0]    sym;
  logic                sym_bad;

  // Divider
  logic          div_start;
  icrt_div_res_t div_res;

  logic                   in_accept;
  logic                   out_free;
  logic                   text_load;
  logic [NUMBER_BITS-1:0] num_u;
  logic [NUMBER_BITS-1:0] num_mag;

  assign item_ready = (state == S_IDLE);
  assign in_accept  = item_valid && item_ready;
  assign out_free   = !text_valid || text_ready;
  // a new character enters the output register this cycle
  assign text_load  = ((state == S_SIGN) || (state == S_PUT)) && out_free;

  // most negative number comes out as 2^(NUMBER_BITS-1), unsigned
  assign num_u   = item.number;
  assign num_mag = num_u[NUMBER_BITS-1] ? (~num_u + 1'b1) : num_u;

  assign chk_more = (chk_addr < base_length);
  assign ndig_dec = ndig - 1'b1;

  // table entry never written reads as zero
  assign sym     = tbl_vld_q ? tbl_q : '0;
  assign sym_bad = (sym == CH_PLUS) || (sym == CH_MINUS) || (sym < CH_LOW) ||
                   (sym > CH_HIGH) || seen[sym[IDX_W-1:0]];

  assign tbl_we    = in_accept && (item.kind == KIND_LOAD);
  assign tbl_re    = ((state == S_CHECK) && chk_more) || (state == S_RD_SYM);
  assign tbl_raddr = (state == S_CHECK) ? chk_addr[IDX_W-1:0] : dbuf_q;

  assign div_start = (state == S_DIV_GO);
  assign dbuf_we   = (state == S_DIV_WAIT) && div_res.done;
  assign dbuf_re   = (state == S_RD_DIG);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_length <= '0;
    end else if (cfg_wen) begin
      base_length <= cfg_wdata;
    end
  end

  // symbol table
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
    end else if (tbl_we) begin
      tbl_valid[item.symbol_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[item.symbol_index] <= item.symbol;
    end
    if (tbl_re) begin
      tbl_q     <= tbl_mem[tbl_raddr];
      tbl_vld_q <= tbl_valid[tbl_raddr];
    end
  end

  // digit buffer
  always_ff @(posedge clk) begin
    if (dbuf_we) begin
      dbuf_mem[ndig[DBUF_AW-1:0]] <= div_res.remainder;
    end
    if (dbuf_re) begin
      dbuf_q <= dbuf_mem[ndig_dec[DBUF_AW-1:0]];
    end
  end

  icrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (magnitude),
    .divisor  (base_length),
    .res      (div_res)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      text_valid <= 1'b0;
      chk_pend   <= 1'b0;
      chk_addr   <= '0;
      ndig       <= '0;
      negative   <= 1'b0;
    end else begin
      if (text_load) begin
        text_valid <= 1'b1;
      end else if (text_ready) begin
        text_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept && (item.kind == KIND_CONVERT)) begin
            magnitude <= num_mag;
            negative  <= num_u[NUMBER_BITS-1];
            ndig      <= '0;
            chk_addr  <= '0;
            chk_pend  <= 1'b0;
            seen      <= '0;
            // radix out of range: drop the beat silently
            if ((base_length >= MIN_BASE) && (base_length <= TOP_BASE)) begin
              state <= S_CHECK;
            end
          end
        end

        // one table read issued per cycle, checked on the next
        S_CHECK: begin
          chk_pend <= chk_more;
          if (chk_more) begin
            chk_addr <= chk_addr + 1'b1;
          end
          if (chk_pend) begin
            seen[sym[IDX_W-1:0]] <= 1'b1;
          end
          if (chk_pend && sym_bad) begin
            state <= S_IDLE;
          end else if (!chk_pend && !chk_more) begin
            state <= S_DIV_GO;
          end
        end

        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_res.done) begin
            magnitude <= div_res.quotient;
            ndig      <= ndig + 1'b1;
            if (div_res.quotient == '0) begin
              state <= negative ? S_SIGN : S_RD_DIG;
            end else begin
              state <= S_DIV_GO;
            end
          end
        end

        S_SIGN: begin
          if (out_free) begin
            text.character <= CH_MINUS;
            text.last      <= 1'b0;
            state          <= S_RD_DIG;
          end
        end

        S_RD_DIG: begin
          ndig  <= ndig_dec;
          state <= S_RD_SYM;
        end

        S_RD_SYM: begin
          state <= S_PUT;
        end

        S_PUT: begin
          if (out_free) begin
            text.character <= sym;
            text.last      <= (ndig == '0);
            state          <= (ndig == '0) ? S_IDLE : S_RD_DIG;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ndig_range: assert property (@(posedge clk) disable iff (rst)
      ndig <= DCNT_W'(NUMBER_BITS))
    else $error("digit count beyond buffer depth");
  a_check_base: assert property (@(posedge clk) disable iff (rst)
      (state == S_CHECK) |-> ((base_length >= MIN_BASE) && (base_length <= TOP_BASE)))
    else $error("alphabet check running with radix out of range");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
      div_res.done |-> (state == S_DIV_WAIT))
    else $error("division result arrived outside wait state");
  a_put_free: assert property (@(posedge clk) disable iff (rst)
      ((state == S_PUT) && text_valid && !text_ready) |=> (state == S_PUT))
    else $error("character dropped while output stalled");
`endif

endmodule

`default_nettype wire

FILE: bench/radix_text_checker.sv
// ----------------------------------------------------------------------------
// radix_text_checker
// Watches the item, text and config ports of the radix text converter. It
// keeps its own copy of the symbol table and radix, spells each accepted
// convert beat into the characters due, and compares every text beat with
// the oldest character still owed.
// ----------------------------------------------------------------------------
module radix_text_checker
  import icrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [BASE_W-1:0] cfg_wdata,
  input  logic              item_valid,
  input  logic              item_ready,
  input  icrt_item_t        item,
  input  logic              text_valid,
  input  logic              text_ready,
  input  icrt_text_t        text,
  output int                fail_count,
  output int                pending,
  output int                convert_count,
  output int                char_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [SYM_W-1:0]  alphabet_table [MAX_BASE];
  logic [BASE_W-1:0] radix;
  icrt_text_t        owed_chars [$];
  icrt_text_t        oldest;
  int                errs;
  int                converts;
  int                chars;

  // Radix in range, every symbol in use printable, not a sign, and unique.
  function automatic bit alphabet_usable();
    logic [SYM_W-1:0] s;
    if (radix < MIN_BASE || radix > TOP_BASE) return 1'b0;
    for (int a = 0; a < int'(radix); a++) begin
      s = alphabet_table[a];
      if (s == CH_PLUS || s == CH_MINUS || s < CH_LOW || s > CH_HIGH) return 1'b0;
      for (int b = a + 1; b < int'(radix); b++)
        if (alphabet_table[b] == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the characters for one number: optional minus, then digits MSD first.
  function automatic void spell_number(input logic [NUMBER_BITS-1:0] value);
    logic [NUMBER_BITS-1:0] mag;
    logic [IDX_W-1:0]       digits [NUMBER_BITS];
    int                     nd;
    icrt_text_t             ch;
    mag = value;
    if (value[NUMBER_BITS-1]) begin
      ch.character = CH_MINUS;
      ch.last      = 1'b0;
      owed_chars.push_back(ch);
      mag = -value;                   // most negative wraps to 2^31 unsigned
    end
    nd = 0;
    do begin
      digits[nd] = IDX_W'(mag % {24'd0, radix});
      nd++;
      mag = mag / {24'd0, radix};
    end while (mag != 0);
    for (int k = nd - 1; k >= 0; k--) begin
      ch.character = alphabet_table[digits[k]];
      ch.last      = (k == 0);
      owed_chars.push_back(ch);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (alphabet_table[i]) alphabet_table[i] = '0;
      radix = '0;
      owed_chars.delete();
      errs      = 0;
      converts  = 0;
      chars     = 0;
    end else begin
      // text first: a beat at this edge belongs to an earlier item
      if (text_valid && text_ready) begin
        chars++;
        if (owed_chars.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected text beat char=%02h last=%0b",
                     $realtime, text.character, text.last);
        end else begin
          oldest = owed_chars.pop_front();
          if (text.character !== oldest.character || text.last !== oldest.last) begin
            errs++;
            if (errs <= 10)
              $display("%0t: text mismatch exp char=%02h last=%0b got char=%02h last=%0b",
                       $realtime, oldest.character, oldest.last,
                       text.character, text.last);
          end
        end
      end
      if (item_valid && item_ready) begin
        if (item.kind == KIND_LOAD) begin
          alphabet_table[item.symbol_index] = item.symbol;
        end else begin
          converts++;
          if (alphabet_usable()) spell_number(item.number);
        end
      end
      if (cfg_wen) radix = cfg_wdata;
    end
    fail_count    <= errs;
    pending       <= owed_chars.size();
    convert_count <= converts;
    char_count    <= chars;
  end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the radix text converter: a directed opening over the edge
// numbers and alphabet faults, then random rounds that each pick a radix,
// load a fresh alphabet and convert numbers amid stray and faulty loads,
// under changing sender and receiver idling. The checker gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import icrt_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 800;   // longer than any convert, even one with no text
  localparam int RANDOM_ITEMS  = 380;
  localparam int N_PRINTABLE   = 93;    // 32..126 less the two sign characters

  logic              clk;
  logic              rst;
  logic              cfg_wen;
  logic [BASE_W-1:0] cfg_wdata;
  logic              item_valid;
  logic              item_ready;
  icrt_item_t        item;
  logic              text_valid;
  logic              text_ready;
  icrt_text_t        text;

  int fail_count;
  int pending;
  int convert_count;
  int char_count;

  int s_idle_pct;      // chance per cycle that the sender holds off
  int r_stall_pct;     // chance per cycle that the receiver stalls
  int items_sent;
  int radix_writes;
  int cycle_count;

  logic [SYM_W-1:0] pool  [N_PRINTABLE];   // every legal digit symbol
  logic [SYM_W-1:0] alpha [MAX_BASE];      // alphabet we meant to load

  integer_to_custom_radix_text_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text)
  );

  radix_text_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .text_valid    (text_valid),
    .text_ready    (text_ready),
    .text          (text),
    .fail_count    (fail_count),
    .pending       (pending),
    .convert_count (convert_count),
    .char_count    (char_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: fresh ready decision every falling edge.
  always @(negedge clk) text_ready <= ($urandom_range(99) >= r_stall_pct);

  // Watchdog: a hung block must not hang the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still owed", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // One item beat. Entered just after a rising edge; returns at the edge that
  // takes it, so valid stays high into the next beat unless the sender idles first.
  task automatic send_beat(input icrt_item_t beat);
    while ($urandom_range(99) < s_idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= beat;
    do @(posedge clk); while (!item_ready);
    items_sent++;
  endtask

  // Load beat; the number field is unused, so fill it with noise.
  task automatic load_symbol(input int idx, input logic [SYM_W-1:0] sym);
    icrt_item_t b;
    b.kind         = KIND_LOAD;
    b.symbol_index = IDX_W'(idx);
    b.symbol       = sym;
    b.number       = $urandom;
    send_beat(b);
  endtask

  // Convert beat; index and symbol are unused, so fill them with noise.
  task automatic convert_number(input logic [NUMBER_BITS-1:0] num);
    icrt_item_t b;
    b.kind         = KIND_CONVERT;
    b.symbol_index = IDX_W'($urandom);
    b.symbol       = SYM_W'($urandom);
    b.number       = num;
    send_beat(b);
  endtask

  // Radix writes only once the block is idle: nothing owed, then a settle
  // pause for a convert that may still be checking a bad alphabet.
  task automatic set_radix(input int value);
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= BASE_W'(value);
    @(negedge clk);
    cfg_wen   <= 1'b0;
    radix_writes++;
  endtask

  // Shuffle the legal symbols and load the first n into positions 0..n-1.
  task automatic load_alphabet(input int n);
    logic [SYM_W-1:0] t;
    int               j;
    for (int i = N_PRINTABLE - 1; i > 0; i--) begin
      j       = $urandom_range(i, 0);
      t       = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (int i = 0; i < n; i++) begin
      alpha[i] = pool[i];
      load_symbol(i, alpha[i]);
    end
  endtask

  // Half full-range values, the rest zero, small magnitudes and the two ends.
  function automatic logic [NUMBER_BITS-1:0] rand_number();
    case ($urandom_range(9))
      0:       return '0;
      1:       return NUMBER_BITS'($urandom_range(300, 1));
      2:       return -NUMBER_BITS'($urandom_range(300, 1));
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // A symbol that spoils the alphabet when written at position pos.
  function automatic logic [SYM_W-1:0] bad_symbol(input int pos, input int n);
    case ($urandom_range(4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return SYM_W'($urandom_range(31, 0));
      3:       return SYM_W'($urandom_range(255, 127));
      default: return (n >= 2) ? alpha[(pos + 1 + $urandom_range(n - 2, 0)) % n] : CH_MINUS;
    endcase
  endfunction

  initial begin
    int p;
    int base;
    int n_load;
    int pos;
    int r;
    int round;
    int random_start;

    rst          = 1'b1;
    cfg_wen      = 1'b0;
    cfg_wdata    = '0;
    item_valid   = 1'b0;
    item         = '0;
    s_idle_pct   = 0;
    r_stall_pct  = 0;
    items_sent   = 0;
    radix_writes = 0;
    cycle_count  = 0;

    p = 0;
    for (int c = CH_LOW; c <= CH_HIGH; c++)
      if (c != CH_PLUS && c != CH_MINUS) begin
        pool[p] = SYM_W'(c);
        p++;
      end
    foreach (alpha[i]) alpha[i] = '0;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // --- directed opening, no idling ---
    convert_number(32'd5);                 // radix still 0 after reset: no text
    set_radix(10);
    for (int i = 0; i < 10; i++) begin
      alpha[i] = SYM_W'(8'h30 + i);        // decimal digit characters
      load_symbol(i, alpha[i]);
    end
    convert_number(32'd0);                 // zero spells symbol 0 alone
    convert_number(32'd12345);
    convert_number(32'hFFFF_FFFF);         // minus one
    convert_number(32'h7FFF_FFFF);
    convert_number(32'h8000_0000);         // most negative, magnitude unsigned
    load_symbol(127, 8'hFF);               // beyond the radix, must not matter
    load_symbol(3, CH_PLUS);               // sign symbol in the alphabet
    convert_number(32'd3);                 // rejected, no text
    load_symbol(3, alpha[3]);
    convert_number(32'd3);
    set_radix(2);
    convert_number(32'h8000_0000);         // longest text: minus and 32 digits
    convert_number(32'd0);
    set_radix(128);                        // top radix, table cannot be legal
    convert_number($urandom);
    set_radix(255);                        // above the top radix
    convert_number($urandom);

    // --- random rounds: radix, fresh alphabet, then a mix of beats ---
    random_start = items_sent;
    round = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      case (round % 4)
        0: begin s_idle_pct = 0;  r_stall_pct = 0;  end
        1: begin s_idle_pct = 69; r_stall_pct = 0;  end
        2: begin s_idle_pct = 0;  r_stall_pct = 69; end
        default: begin s_idle_pct = 18; r_stall_pct = 18; end
      endcase
      r = $urandom_range(99);
      if (r < 8) begin
        case ($urandom_range(4))
          0:       base = 0;
          1:       base = 1;
          2:       base = 128;
          3:       base = 255;
          default: base = $urandom_range(127, N_PRINTABLE + 1);
        endcase
      end else if (r < 20) begin
        base = ($urandom_range(1) != 0) ? 2 : N_PRINTABLE;
      end else if (r < 75) begin
        base = $urandom_range(16, 2);
      end else begin
        base = $urandom_range(N_PRINTABLE, 17);
      end
      n_load = (base > N_PRINTABLE) ? N_PRINTABLE : base;
      set_radix(base);
      load_alphabet(n_load);
      repeat ($urandom_range(16, 8)) begin
        r = $urandom_range(99);
        if (r < 75) begin
          convert_number(rand_number());
        end else if (r < 85 || n_load == 0) begin
          load_symbol($urandom_range(127, n_load), SYM_W'($urandom));   // outside the loaded symbols
        end else begin
          // spoil one symbol, convert against it, then put it back
          pos = $urandom_range(n_load - 1, 0);
          load_symbol(pos, bad_symbol(pos, n_load));
          repeat ($urandom_range(2, 1)) convert_number(rand_number());
          load_symbol(pos, alpha[pos]);
        end
      end
      round++;
    end

    // --- drain and verdict ---
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d item beats (%0d converts) over %0d radix settings in %0d rounds",
             items_sent, convert_count, radix_writes, round);
    $display("checked %0d text beats, %0d mismatches, %0d characters left owed",
             char_count, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
